// ===== rtl/spdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spdc_pkg;

   // Field widths
   localparam int LEVEL_BITS    = 16;
   localparam int BAND_NUM_W    = 7;
   localparam int ACC_BITS      = 23;
   localparam int WACC_BITS     = 30;
   localparam int FRAC_BITS     = 16;
   localparam int IN_DATA_W     = 16;
   localparam int OUT_FIELDS_W  = BAND_NUM_W + LEVEL_BITS + LEVEL_BITS + ACC_BITS
                                  + ACC_BITS + FRAC_BITS;
   localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
   localparam int OUT_USER_W    = 2;

   // Band storage
   localparam int MAX_BANDS_DEF = 128;
   localparam int NBANDS_MIN    = 3;

   // Divide by three as multiply by reciprocal, exact up to 1024 bands
   localparam int THIRD_RECIP   = 2731;
   localparam int THIRD_SHIFT   = 13;

   // Configuration port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int NBANDS_W      = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BANDS    = 2'd1;
   localparam logic [LEVEL_BITS-1:0] DECAY_RESET     = 16'd62915;
   localparam logic [NBANDS_W-1:0]   NBANDS_RESET    = 8'd128;

endpackage

`default_nettype wire

// ===== rtl/spdc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spdc_divider #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 30
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   // One restoring quotient bit per cycle
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, quo_ff[NUM_W-1]};
      diff     = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in   = '0;
         quo_in   = num;
         den_in   = den;
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/spectrum_peak_decay_centroid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ordinary band: the item passes the DECAY, UPDATE and WADD states; no new item is accepted until its result is loaded.
// Last band of a frame: a shift-subtract division of 46 steps in the shared divider for the
// low average, then a second one for the centroid unless the lower-half sum is zero.
// The decay, weight and centroid divisor products share one 23 x 16 multiplier.
// Synchronous active-high reset; afterwards a clearing pass zeroes the band level
// memory, one entry a cycle over all MAX_BANDS entries, while no item is accepted.

module spectrum_peak_decay_centroid
   import spdc_pkg::*;
#(
   parameter int MAX_BANDS = MAX_BANDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: band_magnitude[15:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic                  req_tlast,
   // rsp_tdata: band_number[6:0], smoothed_level[22:7], low_average[38:23],
   //            mid_total[61:39], high_total[84:62], centroid_fraction[100:85], zero pad
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: frame_done[0], centroid_undefined[1]
   output logic [OUT_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W   = $clog2(MAX_BANDS);
   localparam int N_W     = $clog2(MAX_BANDS + 1);
   localparam int HALF_W  = N_W - 1;
   localparam int CMP_W   = (N_W > NBANDS_W) ? N_W : NBANDS_W;
   localparam int P3_W    = N_W + THIRD_SHIFT;
   localparam int MUL_A_W = ACC_BITS;
   localparam int MUL_B1  = (LEVEL_BITS > CNT_W) ? LEVEL_BITS : CNT_W;
   localparam int MUL_B_W = (MUL_B1 > HALF_W) ? MUL_B1 : HALF_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DEN_W   = ACC_BITS + HALF_W;
   localparam int NUM_W   = WACC_BITS + FRAC_BITS;
   localparam int PAD_W   = OUT_DATA_W - OUT_FIELDS_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECAY, ST_UPDATE, ST_WADD,
      ST_LOW_GO, ST_LOW_WAIT, ST_CEN_GO, ST_CEN_WAIT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration and derived band thresholds
   logic [LEVEL_BITS-1:0] decay_ff;
   logic [NBANDS_W-1:0]   nbands_ff;
   logic [N_W-1:0]        n_ff, third_ff, two_third_ff;
   logic [HALF_W-1:0]     half_ff;
   logic [CMP_W-1:0]      nb_ext;
   logic [N_W-1:0]        n_clamp;
   logic [P3_W-1:0]       third_prod;
   logic [N_W-1:0]        third_val;

   // Item and frame state
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      clr_ff, clr_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [LEVEL_BITS-1:0] mag_ff, mag_in;
   logic                  last_ff, last_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [ACC_BITS-1:0]   low_acc_ff, low_acc_in;
   logic [ACC_BITS-1:0]   mid_acc_ff, mid_acc_in;
   logic [ACC_BITS-1:0]   high_acc_ff, high_acc_in;
   logic [ACC_BITS-1:0]   lower_acc_ff, lower_acc_in;
   logic [WACC_BITS-1:0]  wacc_ff, wacc_in;
   logic [LEVEL_BITS-1:0] avg_ff, avg_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic                  undef_ff, undef_in;

   // Shared multiplier
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic                  mul_en;
   logic [MUL_P_W-1:0]    prod_ff, prod_in;

   // Level memory
   logic [LEVEL_BITS-1:0] levels [MAX_BANDS];
   logic [LEVEL_BITS-1:0] rd_ff;
   logic                  mem_we;
   logic [CNT_W-1:0]      mem_addr;
   logic [LEVEL_BITS-1:0] mem_wdata;

   // Divider hookup
   logic                  div_start;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic                  div_done;
   logic [NUM_W-1:0]      div_quo;
   logic [FRAC_BITS-1:0]  div_sat;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   logic [BAND_NUM_W-1:0] o_band_ff, o_band_in;
   logic [LEVEL_BITS-1:0] o_level_ff, o_level_in;
   logic                  o_done_ff, o_done_in;
   logic [LEVEL_BITS-1:0] o_low_ff, o_low_in;
   logic [ACC_BITS-1:0]   o_mid_ff, o_mid_in;
   logic [ACC_BITS-1:0]   o_high_ff, o_high_in;
   logic [FRAC_BITS-1:0]  o_frac_ff, o_frac_in;
   logic                  o_undef_ff, o_undef_in;

   logic [LEVEL_BITS-1:0] decayed;
   logic [LEVEL_BITS-1:0] level_new;
   logic [N_W-1:0]        idx_ext;
   logic                  in_low, in_mid, in_half;
   logic                  out_free;
   logic                  finish_go;

   // Clamp band count and split it into thirds and halves
   always_comb begin
      nb_ext = CMP_W'(nbands_ff);
      if (nb_ext < CMP_W'(NBANDS_MIN)) begin
         n_clamp = N_W'(NBANDS_MIN);
      end else if (nb_ext > CMP_W'(MAX_BANDS)) begin
         n_clamp = N_W'(MAX_BANDS);
      end else begin
         n_clamp = N_W'(nb_ext);
      end
      third_prod = P3_W'(n_clamp) * P3_W'(THIRD_RECIP);
      third_val  = third_prod[THIRD_SHIFT +: N_W];
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_clamp;
      third_ff     <= third_val;
      two_third_ff <= {third_val[N_W-2:0], 1'b0};
      half_ff      <= n_clamp[N_W-1:1];
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= DECAY_RESET;
         nbands_ff <= NBANDS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECAY_FACTOR: decay_ff  <= csr_wdata[LEVEL_BITS-1:0];
            CSR_NUM_BANDS:    nbands_ff <= csr_wdata[NBANDS_W-1:0];
            default:          ;
         endcase
      end
   end

   // Band level memory, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         levels[mem_addr] <= mem_wdata;
      end
      rd_ff <= levels[cnt_ff];
   end

   spdc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign div_sat = (|div_quo[NUM_W-1:FRAC_BITS]) ? {FRAC_BITS{1'b1}} : div_quo[FRAC_BITS-1:0];

   assign decayed   = prod_ff[LEVEL_BITS +: LEVEL_BITS];
   assign level_new = (decayed < mag_ff) ? mag_ff : decayed;
   assign idx_ext   = N_W'(idx_ff);
   assign in_low    = idx_ext < third_ff;
   assign in_mid    = idx_ext < two_third_ff;
   assign in_half   = idx_ext < N_W'(half_ff);
   assign out_free  = !out_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      low_acc_in   = low_acc_ff;
      mid_acc_in   = mid_acc_ff;
      high_acc_in  = high_acc_ff;
      lower_acc_in = lower_acc_ff;
      wacc_in      = wacc_ff;
      avg_in       = avg_ff;
      frac_in      = frac_ff;
      undef_in     = undef_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      o_band_in    = o_band_ff;
      o_level_in   = o_level_ff;
      o_done_in    = o_done_ff;
      o_low_in     = o_low_ff;
      o_mid_in     = o_mid_ff;
      o_high_in    = o_high_ff;
      o_frac_in    = o_frac_ff;
      o_undef_in   = o_undef_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = idx_ff;
      mem_wdata    = level_new;
      div_start    = 1'b0;
      div_num      = NUM_W'(low_acc_ff);
      div_den      = DEN_W'(n_ff);
      finish_go    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CNT_W'(MAX_BANDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in   = cnt_ff;
               mag_in   = req_tdata[LEVEL_BITS-1:0];
               last_in  = req_tlast;
               state_in = ST_DECAY;
            end
         end
         ST_DECAY: begin
            mul_a    = MUL_A_W'(rd_ff);
            mul_b    = MUL_B_W'(decay_ff);
            mul_en   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Store the held level, add it to its third and, in the lower half, to the lower-half sum
            mem_we   = 1'b1;
            level_in = level_new;
            if (in_low) begin
               low_acc_in = low_acc_ff + ACC_BITS'(level_new);
            end else if (in_mid) begin
               mid_acc_in = mid_acc_ff + ACC_BITS'(level_new);
            end else begin
               high_acc_in = high_acc_ff + ACC_BITS'(level_new);
            end
            if (in_half) begin
               lower_acc_in = lower_acc_ff + ACC_BITS'(level_new);
            end
            mul_a    = MUL_A_W'(level_new);
            mul_b    = MUL_B_W'(idx_ff);
            mul_en   = 1'b1;
            state_in = ST_WADD;
         end
         ST_WADD: begin
            if (in_half) begin
               wacc_in = wacc_ff + prod_ff[WACC_BITS-1:0];
            end
            // Centroid divisor for the frame end
            mul_a  = lower_acc_ff;
            mul_b  = MUL_B_W'(half_ff);
            mul_en = 1'b1;
            if (last_ff) begin
               state_in = ST_LOW_GO;
            end else if (out_free) begin
               finish_go = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LOW_GO: begin
            div_start = 1'b1;
            state_in  = ST_LOW_WAIT;
         end
         ST_LOW_WAIT: begin
            if (div_done) begin
               avg_in = div_sat;
               if (lower_acc_ff == '0) begin
                  frac_in  = '0;
                  undef_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  undef_in = 1'b0;
                  state_in = ST_CEN_GO;
               end
            end
         end
         ST_CEN_GO: begin
            div_start = 1'b1;
            div_num   = {wacc_ff, {FRAC_BITS{1'b0}}};
            div_den   = prod_ff[DEN_W-1:0];
            state_in  = ST_CEN_WAIT;
         end
         ST_CEN_WAIT: begin
            if (div_done) begin
               frac_in  = div_sat;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               finish_go = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the result register and advance or clear the frame
      if (finish_go) begin
         out_valid_in = 1'b1;
         o_band_in    = BAND_NUM_W'(idx_ff);
         o_level_in   = level_ff;
         state_in     = ST_IDLE;
         if (last_ff) begin
            o_done_in    = 1'b1;
            o_low_in     = avg_ff;
            o_mid_in     = mid_acc_ff;
            o_high_in    = high_acc_ff;
            o_frac_in    = frac_ff;
            o_undef_in   = undef_ff;
            cnt_in       = '0;
            low_acc_in   = '0;
            mid_acc_in   = '0;
            high_acc_in  = '0;
            lower_acc_in = '0;
            wacc_in      = '0;
         end else begin
            o_done_in  = 1'b0;
            o_low_in   = '0;
            o_mid_in   = '0;
            o_high_in  = '0;
            o_frac_in  = '0;
            o_undef_in = 1'b0;
            cnt_in     = (idx_ff == CNT_W'(MAX_BANDS - 1)) ? '0 : idx_ff + 1'b1;
         end
      end
   end

   assign prod_in = mul_en ? (MUL_P_W'(mul_a) * MUL_P_W'(mul_b)) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         low_acc_ff   <= '0;
         mid_acc_ff   <= '0;
         high_acc_ff  <= '0;
         lower_acc_ff <= '0;
         wacc_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         low_acc_ff   <= low_acc_in;
         mid_acc_ff   <= mid_acc_in;
         high_acc_ff  <= high_acc_in;
         lower_acc_ff <= lower_acc_in;
         wacc_ff      <= wacc_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff     <= idx_in;
      mag_ff     <= mag_in;
      last_ff    <= last_in;
      level_ff   <= level_in;
      prod_ff    <= prod_in;
      avg_ff     <= avg_in;
      frac_ff    <= frac_in;
      undef_ff   <= undef_in;
      o_band_ff  <= o_band_in;
      o_level_ff <= o_level_in;
      o_done_ff  <= o_done_in;
      o_low_ff   <= o_low_in;
      o_mid_ff   <= o_mid_in;
      o_high_ff  <= o_high_in;
      o_frac_ff  <= o_frac_in;
      o_undef_ff <= o_undef_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_frac_ff, o_high_ff, o_mid_ff, o_low_ff,
                        o_level_ff, o_band_ff};
   assign rsp_tuser  = {o_undef_ff, o_done_ff};

endmodule

`default_nettype wire
